>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the stable matching unit.
// Clocked on aclk and disabled while aresetn is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SMU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/smu_pkg.sv
// Shared types and constants of the stable matching unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package smu_pkg;

    localparam int MAX_PAIRS_DEF = 8;
    localparam int CH_W          = 3;   // width of person, rank, choice fields
    localparam int PAIRS_W       = 4;   // width of the pairs_in_use register

    localparam logic [PAIRS_W-1:0] PAIRS_RESET = 4'd8;

    // request kinds (tuser bit 0)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // list owner (tuser bit 1)
    localparam logic SIDE_MAN   = 1'b0;
    localparam logic SIDE_WOMAN = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_PAIRS_IDX = 1'b0;

    typedef struct packed {
        logic load;     // write one preference entry
        logic clear;    // start a run: drop all engagements
        logic select;   // latch the chosen free man and fetch his next choice
        logic propose;  // evaluate the fetched woman
        logic scan;     // compare one rank of her list
        logic emit;     // load one result into the output register
    } smu_cmd_t;

    typedef struct packed {
        logic found;      // some free man still has entries left
        logic prop_scan;  // the woman is engaged: her list must be scanned
        logic scan_done;  // scan decided (accept or reject)
        logic emit_last;  // result being emitted is the final one
        logic out_free;   // output register can take a result
    } smu_status_t;

endpackage

>>> src/smu_ctrl.sv
// Controller of the stable matching unit: sequences load, run and output phases.
// Depends on smu_pkg; drives the datapath through smu_cmd_t, reads smu_status_t.
module smu_ctrl
    import smu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        req_op,
    input  smu_status_t status,
    output smu_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SELECT  = 5'b00010,
        ST_PROPOSE = 5'b00100,
        ST_SCAN    = 5'b01000,
        ST_EMIT    = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_op == OP_RUN) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SELECT;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SELECT: begin
                if (status.found) begin
                    cmd.select = 1'b1;
                    state_next = ST_PROPOSE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PROPOSE: begin
                cmd.propose = 1'b1;
                state_next  = status.prop_scan ? ST_SCAN : ST_SELECT;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_SELECT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/smu_dp.sv
// Datapath of the stable matching unit: preference tables, engagement state,
// proposal and rank scan logic, output register. Depends on smu_pkg.
module smu_dp
    import smu_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PAIRS_W-1:0] pairs_in_use,
    input  logic               ld_side,
    input  logic [CH_W-1:0]    ld_person,
    input  logic [CH_W-1:0]    ld_rank,
    input  logic [CH_W-1:0]    ld_choice,
    input  smu_cmd_t           cmd,
    output smu_status_t        status,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [CH_W-1:0]    m_woman,
    output logic [CH_W-1:0]    m_partner,
    output logic               m_last
);

    localparam int IDX_W = $clog2(MAX_PAIRS);
    localparam int N_W   = $clog2(MAX_PAIRS + 1);
    localparam int DEPTH = MAX_PAIRS * MAX_PAIRS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (N_W > CH_W) ? N_W : CH_W;
    localparam int NC_W  = (N_W > PAIRS_W) ? N_W : PAIRS_W;
    localparam int AX_W  = AW + CMP_W;

    function automatic logic [AW-1:0] tab_addr(input logic [CMP_W-1:0] row,
                                               input logic [CMP_W-1:0] col);
        logic [AX_W-1:0] a;
        a = AX_W'(row) * AX_W'(MAX_PAIRS) + AX_W'(col);
        return a[AW-1:0];
    endfunction

    // preference tables
    logic [CH_W-1:0] man_mem [DEPTH];
    logic [CH_W-1:0] wom_mem [DEPTH];
    logic [CH_W-1:0] man_rd_reg, wom_rd_reg;

    // matching state
    logic [MAX_PAIRS-1:0] engaged_reg;
    logic [MAX_PAIRS-1:0] matched_reg;
    logic [IDX_W-1:0]     partner_reg [MAX_PAIRS];
    logic [N_W-1:0]       prop_cnt_reg [MAX_PAIRS];
    logic [IDX_W-1:0]     man_reg, woman_reg, rank_reg, emit_cnt_reg;

    logic               out_valid_reg, out_last_reg;
    logic [CH_W-1:0]    out_woman_reg, out_partner_reg;

    logic [N_W-1:0]     n_pairs;
    logic [NC_W-1:0]    pairs_ext;
    logic               found;
    logic [IDX_W-1:0]   found_idx;
    logic               ld_ok, man_we, wom_we;
    logic [AW-1:0]      ld_addr, man_raddr, wom_raddr;
    logic [CMP_W-1:0]   w_ext, c_ext, holder_ext, man_ext;
    logic [IDX_W-1:0]   w_idx, part_idx, part_wr_idx;
    logic [IDX_W-1:0]   holder;
    logic               w_in, hit_holder, hit_suitor, scan_end, scan_accept;
    logic               prop_accept;
    logic [N_W-1:0]     rank_inc;
    logic [CMP_W-1:0]   part_out_ext;

    // effective pair count: zero counts as one, clamp to the table size
    always_comb begin
        pairs_ext = NC_W'(pairs_in_use);
        if (pairs_ext == '0) begin
            n_pairs = N_W'(1);
        end else if (pairs_ext > NC_W'(MAX_PAIRS)) begin
            n_pairs = N_W'(MAX_PAIRS);
        end else begin
            n_pairs = pairs_ext[N_W-1:0];
        end
    end

    // lowest-numbered free man with proposals left
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int m = MAX_PAIRS - 1; m >= 0; m--) begin
            if ((N_W'(m) < n_pairs) && !engaged_reg[m] && (prop_cnt_reg[m] < n_pairs)) begin
                found     = 1'b1;
                found_idx = IDX_W'(m);
            end
        end
    end

    // table writes: drop entries beyond the table
    assign ld_ok   = (CMP_W'(ld_person) < CMP_W'(MAX_PAIRS)) &&
                     (CMP_W'(ld_rank) < CMP_W'(MAX_PAIRS));
    assign ld_addr = tab_addr(CMP_W'(ld_person), CMP_W'(ld_rank));
    assign man_we  = cmd.load && ld_ok && (ld_side == SIDE_MAN);
    assign wom_we  = cmd.load && ld_ok && (ld_side == SIDE_WOMAN);

    assign man_raddr = tab_addr(CMP_W'(found_idx), CMP_W'(prop_cnt_reg[found_idx]));

    // proposal evaluation
    assign w_ext       = CMP_W'(man_rd_reg);
    assign w_idx       = w_ext[IDX_W-1:0];
    assign w_in        = w_ext < CMP_W'(n_pairs);
    assign prop_accept = cmd.propose && w_in && !matched_reg[w_idx];

    // rank scan over her list
    assign rank_inc   = N_W'(rank_reg) + N_W'(1);
    assign wom_raddr  = cmd.propose ? tab_addr(w_ext, '0)
                                    : tab_addr(CMP_W'(woman_reg), CMP_W'(rank_inc));
    assign part_idx   = cmd.scan ? woman_reg : emit_cnt_reg;
    assign holder     = partner_reg[part_idx];
    assign c_ext      = CMP_W'(wom_rd_reg);
    assign holder_ext = CMP_W'(holder);
    assign man_ext    = CMP_W'(man_reg);
    assign hit_holder = (c_ext == holder_ext);
    assign hit_suitor = (c_ext == man_ext);
    assign scan_end   = (rank_inc >= n_pairs);
    assign scan_accept = cmd.scan && !hit_holder && hit_suitor;
    assign part_wr_idx = cmd.scan ? woman_reg : w_idx;

    assign part_out_ext = CMP_W'(holder);

    assign status.found     = found;
    assign status.prop_scan = w_in && matched_reg[w_idx];
    assign status.scan_done = hit_holder || hit_suitor || scan_end;
    assign status.emit_last = (N_W'(emit_cnt_reg) + N_W'(1)) == n_pairs;
    assign status.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (man_we) begin
            man_mem[ld_addr] <= ld_choice;
        end
        man_rd_reg <= man_mem[man_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wom_we) begin
            wom_mem[ld_addr] <= ld_choice;
        end
        wom_rd_reg <= wom_mem[wom_raddr];
    end

    always_ff @(posedge aclk) begin
        if (prop_accept || scan_accept) begin
            partner_reg[part_wr_idx] <= man_reg;
        end
        if (cmd.select) begin
            man_reg <= found_idx;
        end
        if (cmd.propose) begin
            woman_reg <= w_idx;
            rank_reg  <= '0;
        end else if (cmd.scan) begin
            rank_reg <= rank_inc[IDX_W-1:0];
        end
        if (cmd.emit) begin
            out_woman_reg   <= CH_W'(emit_cnt_reg);
            out_partner_reg <= matched_reg[emit_cnt_reg] ? part_out_ext[CH_W-1:0] : '0;
            out_last_reg    <= status.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engaged_reg   <= '0;
            matched_reg   <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int m = 0; m < MAX_PAIRS; m++) begin
                prop_cnt_reg[m] <= '0;
            end
        end else begin
            if (cmd.clear) begin
                engaged_reg  <= '0;
                matched_reg  <= '0;
                emit_cnt_reg <= '0;
                for (int m = 0; m < MAX_PAIRS; m++) begin
                    prop_cnt_reg[m] <= '0;
                end
            end
            if (cmd.select) begin
                prop_cnt_reg[found_idx] <= prop_cnt_reg[found_idx] + N_W'(1);
            end
            if (prop_accept) begin
                matched_reg[w_idx]   <= 1'b1;
                engaged_reg[man_reg] <= 1'b1;
            end
            if (scan_accept) begin
                // old partner becomes free again
                engaged_reg[holder]  <= 1'b0;
                engaged_reg[man_reg] <= 1'b1;
            end
            if (cmd.emit) begin
                emit_cnt_reg <= emit_cnt_reg + IDX_W'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_woman   = out_woman_reg;
    assign m_partner = out_partner_reg;
    assign m_last    = out_last_reg;

endmodule

>>> src/stable_matching_unit.sv
// Stable matching unit (Gale-Shapley, men propose).
// Input channel s_*: each request either writes one preference entry (op 0)
// or runs the matching over the first pairs_in_use men and women (op 1).
// Result channel m_*: a run returns one result per woman 0..n-1, woman and
// partner in m_tdata, m_tlast on the final one; loads return nothing.
// Sequence: a load is written as it is taken. A run has a start step, then per
// proposal a pick step (pick man and fetch his choice) and an evaluate step, plus
// one scan step for each rank of an engaged woman's list compared, then a step
// to find no free man left and one emit step per result. One read port on each
// preference table and the single proposal sequencer set this order of steps.
// A new request is taken only when no run is in progress; the last result of
// a run may still wait in the output register while the next requests enter.
// A stalled receiver (m_tready low) holds the result and pauses the run output.
// Reset (aresetn low, synchronous) drops all engagements, empties the output
// and sets pairs_in_use to 8; preference tables keep no reset value and must be
// written before a run reads them. pairs_in_use is written over APB at 0x0.
module stable_matching_unit
    import smu_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // person[2:0], rank[5:3], choice[8:6], zero pad
    input  logic [1:0]  s_tuser,   // op[0], side[1]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // woman[2:0], partner[5:3], zero pad
    output logic        m_tlast
);

`include "assert_macros.svh"

    logic [PAIRS_W-1:0] pairs_reg;
    logic               cfg_write;
    smu_cmd_t           dp_cmd;
    smu_status_t        dp_status;
    logic [CH_W-1:0]    res_woman, res_partner;
    logic               run_accept, load_accept, out_open;
    logic [PAIRS_W-1:0] cfg_value;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_PAIRS_IDX);
    assign prdata    = (paddr[2] == REG_PAIRS_IDX) ? 32'(pairs_reg) : '0;
    assign cfg_value = pwdata[PAIRS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_reg <= PAIRS_RESET;
        end else if (cfg_write) begin
            pairs_reg <= cfg_value;
        end
    end

    smu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_op   (s_tuser[0]),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    smu_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pairs_in_use (pairs_reg),
        .ld_side      (s_tuser[1]),
        .ld_person    (s_tdata[2:0]),
        .ld_rank      (s_tdata[5:3]),
        .ld_choice    (s_tdata[8:6]),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_woman      (res_woman),
        .m_partner    (res_partner),
        .m_last       (m_tlast)
    );

    assign m_tdata = {2'b00, res_partner, res_woman};

    assign run_accept  = s_tvalid && s_tready && (s_tuser[0] == OP_RUN);
    assign load_accept = s_tvalid && s_tready && (s_tuser[0] == OP_LOAD);
    assign out_open    = !m_tvalid || m_tready;

    `SMU_ASSERT_NEXT(a_run_blocks_input, run_accept, !s_tready, "request accepted during a run")
    `SMU_ASSERT_NEXT(a_load_no_result, load_accept && !m_tvalid, !m_tvalid, "load made a result")
    `SMU_ASSERT_NOW(a_emit_into_free_slot, dp_cmd.emit, out_open, "result overwrote a pending one")
    `SMU_ASSERT_NEXT(a_cfg_write_lands, cfg_write, pairs_reg == $past(cfg_value), "write lost")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for stable_matching_unit: loads preference tables, runs matchings
// at several pairs_in_use settings and checks every reported pairing against a local predictor.
// Depends on smu_pkg and the stable_matching_unit RTL only.
module testbench;
    import smu_pkg::*;

    typedef struct {
        logic       op;
        logic       side;
        logic [2:0] person;
        logic [2:0] rank;
        logic [2:0] choice;
    } pref_req_t;

    typedef struct {
        logic [2:0] woman;
        logic [2:0] partner;
        logic       last;
    } pairing_t;

    localparam int          NUM_SLOTS = 8;
    localparam int unsigned NOBODY    = 32'hFFFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // predictor state
    logic [2:0]  man_list   [NUM_SLOTS][NUM_SLOTS];
    logic [2:0]  woman_list [NUM_SLOTS][NUM_SLOTS];
    logic [3:0]  pairs_reg = PAIRS_RESET;
    pairing_t    pairings_due [$];

    // stimulus bookkeeping
    pref_req_t   pending [$];
    pref_req_t   cur_req;
    bit          man_written   [NUM_SLOTS][NUM_SLOTS];
    bit          woman_written [NUM_SLOTS][NUM_SLOTS];
    int unsigned gen_pairs = 8;
    int          reqs_outstanding = 0;
    int          items_made = 0;
    int          mismatches = 0;
    logic        req_fire = 1'b0;
    bit          steady = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          phase_pairs [8] = '{3, 5, 8, 2, 15, 6, 4, 7};

    stable_matching_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned effective_pairs(input logic [3:0] value);
        if (value == 4'd0)
            return 1;
        if (32'(value) > NUM_SLOTS)
            return NUM_SLOTS;
        return 32'(value);
    endfunction

    // Men propose in Gale-Shapley order; queue one pairing per woman on a run.
    task automatic register_request(input pref_req_t req);
        int unsigned n, m, w, holder, r;
        int unsigned held_by [NUM_SLOTS];
        int unsigned tries [NUM_SLOTS];
        bit          engaged [NUM_SLOTS];
        bit          take;
        pairing_t    pr;
        if (req.op == OP_LOAD) begin
            if (req.side == SIDE_MAN)
                man_list[req.person][req.rank] = req.choice;
            else
                woman_list[req.person][req.rank] = req.choice;
            return;
        end
        n = effective_pairs(pairs_reg);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            held_by[i] = NOBODY;
            tries[i]   = 0;
            engaged[i] = 1'b0;
        end
        forever begin
            m = n;
            for (int i = int'(n) - 1; i >= 0; i--)
                if (!engaged[i] && tries[i] < n)
                    m = i;
            if (m == n)
                break;
            w = 32'(man_list[m][tries[m]]);
            tries[m]++;
            // proposal to a woman outside the active set is refused
            if (w >= n)
                continue;
            if (held_by[w] == NOBODY) begin
                held_by[w] = m;
                engaged[m] = 1'b1;
            end else begin
                holder = held_by[w];
                take = 1'b0;
                for (r = 0; r < n; r++) begin
                    if (32'(woman_list[w][r]) == holder)
                        break;
                    if (32'(woman_list[w][r]) == m) begin
                        take = 1'b1;
                        break;
                    end
                end
                if (take) begin
                    held_by[w]      = m;
                    engaged[m]      = 1'b1;
                    engaged[holder] = 1'b0;
                end
            end
        end
        for (w = 0; w < n; w++) begin
            pr.woman   = w[2:0];
            pr.partner = (held_by[w] == NOBODY) ? 3'd0 : held_by[w][2:0];
            pr.last    = (w + 1 == n);
            pairings_due.push_back(pr);
        end
    endtask

    task automatic push_req(input pref_req_t req);
        if (req.op == OP_LOAD) begin
            if (req.side == SIDE_MAN)
                man_written[req.person][req.rank] = 1'b1;
            else
                woman_written[req.person][req.rank] = 1'b1;
        end
        pending.push_back(req);
        reqs_outstanding++;
        items_made++;
    endtask

    task automatic push_load(input logic side, input logic [2:0] person,
                             input logic [2:0] rank, input logic [2:0] choice);
        pref_req_t req;
        req.op     = OP_LOAD;
        req.side   = side;
        req.person = person;
        req.rank   = rank;
        req.choice = choice;
        push_req(req);
    endtask

    // Fill every table entry the run may read, then request the run.
    task automatic queue_run();
        pref_req_t req;
        for (int p = 0; p < int'(gen_pairs); p++) begin
            for (int k = 0; k < int'(gen_pairs); k++) begin
                if (!man_written[p][k])
                    push_load(SIDE_MAN, 3'(p), 3'(k), 3'($urandom_range(0, gen_pairs - 1)));
                if (!woman_written[p][k])
                    push_load(SIDE_WOMAN, 3'(p), 3'(k), 3'($urandom_range(0, gen_pairs - 1)));
            end
        end
        req.op     = OP_RUN;
        req.side   = 1'($urandom_range(0, 1));
        req.person = 3'($urandom_range(0, 7));
        req.rank   = 3'($urandom_range(0, 7));
        req.choice = 3'($urandom_range(0, 7));
        push_req(req);
    endtask

    // Wait until every request is taken and every pairing has come back.
    task automatic settle();
        while (reqs_outstanding != 0 || pairings_due.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_pairs(input logic [3:0] value);
        settle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PAIRS_IDX, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pairs_reg = value;
        gen_pairs = effective_pairs(value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic log_mismatch(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    // request side: sample the handshake
    always @(posedge aclk) begin
        req_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            register_request(cur_req);
            reqs_outstanding--;
        end
    end

    // request side: drive the next request, or hold off for a burst
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (src_gap != 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!steady && pending.size() != 0 && $urandom_range(0, 7) == 0) begin
                src_gap  <= $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                cur_req = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, cur_req.choice, cur_req.rank, cur_req.person};
                s_tuser  <= {cur_req.side, cur_req.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: stall in bursts
    always @(negedge aclk) begin
        if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result side: compare against the oldest predicted pairing
    always @(posedge aclk) begin
        pairing_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pairings_due.size() == 0) begin
                log_mismatch($sformatf("unexpected result: woman %0d partner %0d last %0b",
                                       m_tdata[2:0], m_tdata[5:3], m_tlast));
            end else begin
                want = pairings_due.pop_front();
                if (m_tdata[2:0] !== want.woman || m_tdata[5:3] !== want.partner
                        || m_tlast !== want.last)
                    log_mismatch($sformatf(
                        "result mismatch: expected woman %0d partner %0d last %0b, got %0d %0d %0b",
                        want.woman, want.partner, want.last,
                        m_tdata[2:0], m_tdata[5:3], m_tlast));
            end
        end
    end

    initial begin
        int          perm [NUM_SLOTS];
        int          phase_end;
        int unsigned np;
        int          j, tmp, pick;
        logic        sel_side;
        logic [2:0]  sel_person;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // two pairs: both men want woman 1, she trades up to man 1
        write_pairs(4'd2);
        push_load(SIDE_MAN,   0, 0, 1);
        push_load(SIDE_MAN,   0, 1, 0);
        push_load(SIDE_MAN,   1, 0, 1);
        push_load(SIDE_MAN,   1, 1, 0);
        push_load(SIDE_WOMAN, 0, 0, 0);
        push_load(SIDE_WOMAN, 0, 1, 1);
        push_load(SIDE_WOMAN, 1, 0, 1);
        push_load(SIDE_WOMAN, 1, 1, 0);
        queue_run();
        // out-of-range choices, a woman who lists neither man, a man who runs dry
        push_load(SIDE_MAN,   0, 0, 7);
        push_load(SIDE_MAN,   0, 1, 1);
        push_load(SIDE_WOMAN, 1, 0, 7);
        push_load(SIDE_WOMAN, 1, 1, 6);
        push_load(SIDE_MAN,   1, 1, 1);
        queue_run();
        // entries beyond the active set are stored but unused
        push_load(SIDE_MAN,   7, 7, 7);
        push_load(SIDE_WOMAN, 7, 7, 7);
        push_load(SIDE_WOMAN, 7, 0, 0);
        queue_run();
        // single pair whose only choice is out of range, then zero read as one
        write_pairs(4'd1);
        queue_run();
        write_pairs(4'd0);
        push_load(SIDE_MAN, 0, 0, 0);
        queue_run();

        for (int p = 0; p < 8; p++) begin
            write_pairs(4'(phase_pairs[p]));
            if (p == 7)
                steady = 1'b1;
            np = gen_pairs;
            phase_end = items_made + 56;
            while (items_made < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // rewrite one list as a fresh permutation
                    for (int i = 0; i < int'(np); i++)
                        perm[i] = i;
                    for (int i = int'(np) - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        tmp = perm[i];
                        perm[i] = perm[j];
                        perm[j] = tmp;
                    end
                    sel_side   = 1'($urandom_range(0, 1));
                    sel_person = 3'($urandom_range(0, np - 1));
                    for (int i = 0; i < int'(np); i++)
                        push_load(sel_side, sel_person, 3'(i), 3'(perm[i]));
                    if ($urandom_range(0, 1) == 1)
                        queue_run();
                end else if (pick < 8) begin
                    repeat ($urandom_range(1, 3))
                        push_load(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end else begin
                    queue_run();
                end
            end
            queue_run();
        end
        settle();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && pairings_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/smu_pkg.sv
src/smu_ctrl.sv
src/smu_dp.sv
src/stable_matching_unit.sv
dv/testbench.sv
